/* rtl/asoc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asoc_pkg: shared types and constants
// Field widths, table entry layout, pipeline tag and result formats for the
// actuator scale / offset / clamp block.
// ----------------------------------------------------------------------------
package asoc_pkg;

  localparam int MAX_ACTUATORS = 4096;
  localparam int POS_W         = $clog2(MAX_ACTUATORS);
  localparam int ADDR_W        = POS_W + 1;            // bank bit + position
  localparam int TBL_DEPTH     = 2 * MAX_ACTUATORS;

  localparam int COUNT_W  = 13;
  localparam int VALUE_W  = 40;
  localparam int SCALE_W  = 32;
  localparam int LIMIT_W  = 16;
  localparam int CMD_W    = 16;
  localparam int CLIP_W   = 14;
  localparam int FRAC_W   = 16;
  localparam int MODE_W   = 2;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - (CMD_W + POS_W + 2 + CLIP_W);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = COUNT_W;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int CREDIT_W   = FIFO_PTR_W + 1;

  localparam logic [CLIP_W-1:0] CLIP_SAT = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE  = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_COMMIT = 2'd2
  } mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ACT_COUNT = 2'd0,
    REG_SCALE_EN  = 2'd1,
    REG_OFFSET_EN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic        [LIMIT_W-1:0] hi_lim;
    logic        [LIMIT_W-1:0] lo_lim;
    logic signed [VALUE_W-1:0] offset;
    logic signed [SCALE_W-1:0] scale;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             first;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic              last;
    logic [CLIP_W-1:0] clip;
    logic              hi;
    logic              lo;
    logic [POS_W-1:0]  num;
    logic [CMD_W-1:0]  cmd;
  } result_t;

endpackage

/* rtl/asoc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asoc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module asoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/asoc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asoc_datapath: scale, offset, round and clamp pipeline
// Split 40x32 multiply, floor and saturate, offset add with rounding,
// truncation toward zero, clamp and per-frame clip count.
// ----------------------------------------------------------------------------
module asoc_datapath import asoc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      scale_en,
  input  logic                      offset_en,
  input  logic                      in_valid,
  input  tag_t                      in_tag,
  input  logic signed [VALUE_W-1:0] in_value,
  input  entry_t                    entry,
  output logic                      out_valid,
  output result_t                   out_res
);

  localparam int SPLIT  = VALUE_W / 2;
  localparam int PPH_W  = SCALE_W + (VALUE_W - SPLIT);
  localparam int PPL_W  = SCALE_W + SPLIT + 1;
  localparam int PROD_W = VALUE_W + SCALE_W;
  localparam int SH_W   = PROD_W - FRAC_W;
  localparam int T_W    = VALUE_W + 2;
  localparam int R_W    = T_W - FRAC_W;

  localparam logic signed [VALUE_W-1:0] VAL_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [T_W-1:0]     HALF     = T_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [T_W-1:0]     FRAC_ONE = (T_W'(1) <<< FRAC_W) - T_W'(1);

  // stage 1: partial products
  logic                      s1_valid;
  tag_t                      s1_tag;
  logic signed [VALUE_W-1:0] s1_value;
  logic signed [VALUE_W-1:0] s1_offset;
  logic [LIMIT_W-1:0]        s1_lo_lim;
  logic [LIMIT_W-1:0]        s1_hi_lim;
  logic signed [PPH_W-1:0]   s1_pp_hi;
  logic signed [PPL_W-1:0]   s1_pp_lo;
  logic signed [PPH_W-1:0]   pp_hi_next;
  logic signed [PPL_W-1:0]   pp_lo_next;

  // stage 2: product floored to Q40.16
  logic                      s2_valid;
  tag_t                      s2_tag;
  logic signed [VALUE_W-1:0] s2_value;
  logic signed [VALUE_W-1:0] s2_offset;
  logic [LIMIT_W-1:0]        s2_lo_lim;
  logic [LIMIT_W-1:0]        s2_hi_lim;
  logic signed [SH_W-1:0]    s2_prod;
  logic signed [PROD_W-1:0]  prod_next;

  // stage 3: saturated, scale selected
  logic                      s3_valid;
  tag_t                      s3_tag;
  logic signed [VALUE_W-1:0] s3_x;
  logic signed [VALUE_W-1:0] s3_offset;
  logic [LIMIT_W-1:0]        s3_lo_lim;
  logic [LIMIT_W-1:0]        s3_hi_lim;
  logic signed [VALUE_W-1:0] sat_next;
  logic signed [VALUE_W-1:0] x_next;

  // stage 4: offset plus one half
  logic                      s4_valid;
  tag_t                      s4_tag;
  logic signed [T_W-1:0]     s4_t;
  logic [LIMIT_W-1:0]        s4_lo_lim;
  logic [LIMIT_W-1:0]        s4_hi_lim;
  logic signed [T_W-1:0]     t_next;

  // stage 5: integer, truncated toward zero
  logic                      s5_valid;
  tag_t                      s5_tag;
  logic signed [R_W-1:0]     s5_r;
  logic [LIMIT_W-1:0]        s5_lo_lim;
  logic [LIMIT_W-1:0]        s5_hi_lim;
  logic signed [T_W-1:0]     t_adj;

  // clamp and clip count
  logic [CLIP_W-1:0]         clip_total;
  logic [CLIP_W-1:0]         clip_base;
  logic [CLIP_W:0]           clip_sum;
  logic [CLIP_W-1:0]         clip_new;
  logic                      lo_hit;
  logic                      hi_hit;
  logic [CMD_W-1:0]          cmd;

  // v = v_hi * 2^SPLIT + v_lo, v_lo unsigned
  assign pp_hi_next = entry.scale * $signed(in_value[VALUE_W-1:SPLIT]);
  assign pp_lo_next = entry.scale * $signed({1'b0, in_value[SPLIT-1:0]});

  assign prod_next = (PROD_W'(s1_pp_hi) <<< SPLIT) + PROD_W'(s1_pp_lo);

  always_comb begin
    if (s2_prod[SH_W-1:VALUE_W-1] == '0 || s2_prod[SH_W-1:VALUE_W-1] == '1) begin
      sat_next = s2_prod[VALUE_W-1:0];
    end else if (s2_prod[SH_W-1]) begin
      sat_next = VAL_MIN;
    end else begin
      sat_next = VAL_MAX;
    end
    x_next = scale_en ? sat_next : s2_value;
  end

  assign t_next = T_W'(s3_x) + (offset_en ? T_W'(s3_offset) : T_W'(0)) + HALF;

  // negative: add 1 - 2^-16 before the arithmetic shift
  assign t_adj = s4_t[T_W-1] ? (s4_t + FRAC_ONE) : s4_t;

  always_comb begin
    lo_hit = s5_r < R_W'($signed({1'b0, s5_lo_lim}));
    hi_hit = s5_r > R_W'($signed({1'b0, s5_hi_lim}));
    cmd    = s5_r[CMD_W-1:0];
    if (hi_hit) begin
      cmd = s5_hi_lim;
    end else if (lo_hit) begin
      cmd = s5_lo_lim;
    end
    clip_base = s5_tag.first ? '0 : clip_total;
    clip_sum  = {1'b0, clip_base} + (CLIP_W+1)'(lo_hit) + (CLIP_W+1)'(hi_hit);
    clip_new  = (clip_sum > (CLIP_W+1)'(CLIP_SAT)) ? CLIP_SAT : clip_sum[CLIP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      s4_valid   <= 1'b0;
      s5_valid   <= 1'b0;
      clip_total <= '0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      if (s5_valid) begin
        clip_total <= clip_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_tag    <= in_tag;
    s1_value  <= in_value;
    s1_offset <= entry.offset;
    s1_lo_lim <= entry.lo_lim;
    s1_hi_lim <= entry.hi_lim;
    s1_pp_hi  <= pp_hi_next;
    s1_pp_lo  <= pp_lo_next;

    s2_tag    <= s1_tag;
    s2_value  <= s1_value;
    s2_offset <= s1_offset;
    s2_lo_lim <= s1_lo_lim;
    s2_hi_lim <= s1_hi_lim;
    s2_prod   <= prod_next[PROD_W-1:FRAC_W];

    s3_tag    <= s2_tag;
    s3_x      <= x_next;
    s3_offset <= s2_offset;
    s3_lo_lim <= s2_lo_lim;
    s3_hi_lim <= s2_hi_lim;

    s4_tag    <= s3_tag;
    s4_t      <= t_next;
    s4_lo_lim <= s3_lo_lim;
    s4_hi_lim <= s3_hi_lim;

    s5_tag    <= s4_tag;
    s5_r      <= t_adj[T_W-1:FRAC_W];
    s5_lo_lim <= s4_lo_lim;
    s5_hi_lim <= s4_hi_lim;
  end

  assign out_valid    = s5_valid;
  assign out_res.last = s5_tag.last;
  assign out_res.clip = clip_new;
  assign out_res.hi   = hi_hit;
  assign out_res.lo   = lo_hit;
  assign out_res.num  = s5_tag.pos;
  assign out_res.cmd  = cmd;

endmodule

/* rtl/asoc_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asoc_out_fifo: result buffer
// Holds finished results until the downstream side takes them. Space is
// reserved upstream, so a push always finds room.
// ----------------------------------------------------------------------------
module asoc_out_fifo import asoc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    out_valid,
  output result_t out_data
);

  result_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_PTR_W:0]    count;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/actuator_scale_offset_clamp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_scale_offset_clamp: per-actuator gain, offset and clamp
// Turns actuator demands into 16-bit DAC commands using double-banked
// per-actuator tables, and counts clips per frame.
// ----------------------------------------------------------------------------
// Takes one item per clock while input ready is high. A demand sample passes
// through RAM read, two-part multiply, sum, saturate, offset add, round and
// clamp into a 16-entry result buffer. Table writes and commits produce no
// output. Input ready drops only when 16 samples are in flight or buffered,
// i.e. when the downstream side has stopped taking results. All four tables
// live in one 8192 x 104 RAM holding both banks; table writes go to the
// inactive bank and a commit swaps banks at the next frame start. The tables
// are not cleared at reset: every entry must be written before its bank is
// made active.
// ----------------------------------------------------------------------------
module actuator_scale_offset_clamp import asoc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // entry_index, sample_value, entry_scale, entry_offset, entry_min, entry_max
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // mode
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // command, actuator_number, clipped_low, clipped_high, frame_clip_count
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  // configuration
  logic [COUNT_W-1:0]    act_count;
  logic                  scale_en;
  logic                  offset_en;

  // frame and bank state
  logic                  active_bank;
  logic                  swap_pending;
  logic [POS_W-1:0]      frame_pos;

  logic                  accept;
  mode_t                 mode;
  logic                  write_acc;
  logic                  sample_acc;
  logic [COUNT_W-1:0]    count_eff;
  logic [COUNT_W-1:0]    pos_plus;
  logic                  first;
  logic                  last;
  logic                  bank_rd;

  entry_t                wr_entry;
  entry_t                rd_entry;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;

  logic                  p0_valid;
  tag_t                  p0_tag;
  logic signed [VALUE_W-1:0] p0_value;

  logic                  res_valid;
  result_t               res;
  logic                  pop;
  result_t               out_res;
  logic [CREDIT_W-1:0]   credit;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_count <= COUNT_W'(1);
      scale_en  <= 1'b0;
      offset_en <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ACT_COUNT: act_count <= cfg_wr_data;
        REG_SCALE_EN:  scale_en  <= cfg_wr_data[0];
        REG_OFFSET_EN: offset_en <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;
  assign mode   = mode_t'(s_tuser);

  always_comb begin
    write_acc  = 1'b0;
    sample_acc = 1'b0;
    case (mode)
      MODE_WRITE:  write_acc  = accept;
      MODE_SAMPLE: sample_acc = accept;
      default: ;
    endcase
  end

  always_comb begin
    if (act_count == '0) begin
      count_eff = COUNT_W'(1);
    end else if (act_count > COUNT_W'(MAX_ACTUATORS)) begin
      count_eff = COUNT_W'(MAX_ACTUATORS);
    end else begin
      count_eff = act_count;
    end
  end

  assign pos_plus = COUNT_W'(frame_pos) + COUNT_W'(1);
  assign last     = (pos_plus >= count_eff);
  assign first    = (frame_pos == '0);
  // a pending commit takes effect on the first sample of a frame
  assign bank_rd  = (first && swap_pending) ? ~active_bank : active_bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank  <= 1'b0;
      swap_pending <= 1'b0;
      frame_pos    <= '0;
    end else if (accept) begin
      case (mode)
        MODE_COMMIT: swap_pending <= 1'b1;
        MODE_SAMPLE: begin
          if (first && swap_pending) begin
            active_bank  <= ~active_bank;
            swap_pending <= 1'b0;
          end
          frame_pos <= last ? '0 : pos_plus[POS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign wr_entry.scale  = $signed(s_tdata[83:52]);
  assign wr_entry.offset = $signed(s_tdata[123:84]);
  assign wr_entry.lo_lim = s_tdata[139:124];
  assign wr_entry.hi_lim = s_tdata[155:140];
  assign waddr           = {~active_bank, s_tdata[POS_W-1:0]};
  assign raddr           = {bank_rd, frame_pos};

  asoc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_tables (
    .clk   (clk),
    .we    (write_acc),
    .waddr (waddr),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  // sample tag and value line up with the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= sample_acc;
    end
  end

  always_ff @(posedge clk) begin
    p0_tag.pos   <= frame_pos;
    p0_tag.first <= first;
    p0_tag.last  <= last;
    p0_value     <= $signed(s_tdata[51:12]);
  end

  asoc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .scale_en  (scale_en),
    .offset_en (offset_en),
    .in_valid  (p0_valid),
    .in_tag    (p0_tag),
    .in_value  (p0_value),
    .entry     (rd_entry),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign pop = m_tvalid && m_tready;

  asoc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_data  (out_res)
  );

  // one credit per sample in the pipe or in the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CREDIT_W'(sample_acc) - CREDIT_W'(pop);
    end
  end

  assign s_tready = (credit < CREDIT_W'(FIFO_DEPTH));

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_res.clip, out_res.hi, out_res.lo,
                    out_res.num, out_res.cmd};
  assign m_tlast = out_res.last;

endmodule

/* rtl/asoc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asoc_checker: port-level checks
// Frame numbering, clip count and output hold behavior seen at the ports.
// ----------------------------------------------------------------------------
module asoc_checker import asoc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_wr_en,
  input logic [CFG_ADDR_W-1:0] cfg_addr,
  input logic [CFG_DATA_W-1:0] cfg_wr_data,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic [MODE_W-1:0]     s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  logic              out_acc;
  logic [POS_W-1:0]  num;
  logic [CLIP_W-1:0] clip;
  logic              prev_last;
  logic [POS_W-1:0]  prev_num;
  logic [CLIP_W-1:0] prev_clip;

  assign out_acc = m_tvalid && m_tready;
  assign num     = m_tdata[27:16];
  assign clip    = m_tdata[43:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_last <= 1'b1;
      prev_num  <= '0;
      prev_clip <= '0;
    end else if (out_acc) begin
      prev_last <= m_tlast;
      prev_num  <= num;
      prev_clip <= clip;
    end
  end

  // frame opens at actuator 0 and counts up by one
  a_numbering: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> ((prev_last && num == '0) ||
                 (!prev_last && num == prev_num + POS_W'(1))))
    else $error("actuator number out of sequence");

  // first actuator's clip count is its own clips only
  a_clip_start: assert property (@(posedge clk) disable iff (rst)
    (out_acc && num == '0) |->
      (clip == CLIP_W'(m_tdata[28]) + CLIP_W'(m_tdata[29])))
    else $error("clip count not restarted at frame start");

  a_clip_mono: assert property (@(posedge clk) disable iff (rst)
    (out_acc && !prev_last) |-> (clip >= prev_clip))
    else $error("clip count fell within a frame");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind actuator_scale_offset_clamp asoc_checker u_checker (.*);
